// ===== design/pts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; used by pts_slot_ram and the top level.
`default_nettype none

package pts_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int CD_W          = 32;
    localparam int PRIO_W        = 3;
    localparam int SLOT_OUT_W    = 3;
    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 8;

    localparam logic FUNC_CREATE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic MODE_RR     = 1'b0;
    localparam logic MODE_PRIO   = 1'b1;

    typedef enum logic [1:0] {
        KIND_CREATED  = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_IDLE     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CREATE = 4'b0010,
        S_SEARCH = 4'b0100,
        S_SCAN   = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CD_W-1:0]   countdown;
        logic [CD_W-1:0]   period;
        logic [PRIO_W-1:0] prio;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

// ===== design/pts_slot_ram.sv =====
// Slot table memory: one write port, one registered read port.
// Depends on pts_pkg for default widths.
`default_nettype none

module pts_slot_ram #(
    parameter int DEPTH  = pts_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = pts_pkg::ENTRY_W
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/periodic_task_tick_scheduler_top.sv =====
// Periodic task tick scheduler, top level: control sequencer and active flags.
// Depends on pts_pkg and pts_slot_ram.
//
//  channel | direction | signals                          | contents
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | create or tick item
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser | one result, m_tlast
//          |           | m_tlast                          | on the final one
//  cfg_    | in        | cfg_valid cfg_ready cfg_data     | scheduler_mode
//
// Round-robin tick: one slot read per cycle through the single read port of
// the slot memory while the scan is not stalled. Priority tick: a search pass,
// then an update pass. TABLE = min(NUM_SLOTS, 8).
// Reset clears the active flags at once; no clearing pass.
// In round-robin mode a held output stalls the scan until its transfer completes.
`default_nettype none

module periodic_task_tick_scheduler_top #(
    parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] start_delay, [63:32] run_period, [66:64] task_priority, rest zero
    input  wire logic [pts_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] func
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] task_slot, rest zero
    output logic      [pts_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [1:0] result_kind
    output logic      [1:0]                      m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_data
);

    localparam int TABLE     = (NUM_SLOTS < pts_pkg::MAX_RESULTS) ? NUM_SLOTS
                                                                  : pts_pkg::MAX_RESULTS;
    localparam int IDX_W     = (TABLE > 1) ? $clog2(TABLE) : 1;
    localparam int CNT_IDX_W = $clog2(TABLE + 1);
    localparam int CD_W      = pts_pkg::CD_W;
    localparam int PRIO_W    = pts_pkg::PRIO_W;
    localparam int SLOT_W    = pts_pkg::SLOT_OUT_W;

    pts_pkg::state_t      state_reg, state_next;
    logic                 mode_reg;
    logic [TABLE-1:0]     active_reg, active_next;
    logic [CNT_IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic                 eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;

    logic                 out_valid_reg, out_valid_next;
    pts_pkg::kind_t       out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic                 out_last_reg, out_last_next;

    logic [CD_W-1:0]      in_delay_reg;
    logic [CD_W-1:0]      in_period_reg;
    logic [PRIO_W-1:0]    in_prio_reg;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    pts_pkg::slot_entry_t ram_wr_data;
    logic                 ram_rd_en;
    pts_pkg::slot_entry_t ram_rd_data;

    logic                 out_free;
    logic                 issue;
    logic                 pass_done;
    logic                 cur_active;
    logic                 cd_zero;
    logic                 is_best;
    logic                 cand;
    logic                 rr_due;
    logic                 advance;
    logic [CD_W-1:0]      cd_src;
    logic [CD_W-1:0]      upd_cd;
    logic [IDX_W-1:0]     free_idx;
    logic                 table_full;

    pts_slot_ram #(
        .DEPTH  (TABLE),
        .ADDR_W (IDX_W),
        .DATA_W (pts_pkg::ENTRY_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == pts_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(pts_pkg::OUT_DATA_W - SLOT_W){1'b0}}, out_slot_reg};
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_last_reg;

    assign out_free   = !out_valid_reg || m_tready;
    assign issue      = (scan_idx_reg != CNT_IDX_W'(TABLE));
    assign pass_done  = !issue && !eval_valid_reg;
    assign cur_active = active_reg[eval_idx_reg];
    assign cd_zero    = (ram_rd_data.countdown == '0);
    assign is_best    = pend_valid_reg && (pend_slot_reg == eval_idx_reg);
    assign cand       = cur_active && cd_zero
                        && (!pend_valid_reg || (ram_rd_data.prio < best_prio_reg));
    assign rr_due     = (state_reg == pts_pkg::S_SCAN) && (mode_reg == pts_pkg::MODE_RR)
                        && eval_valid_reg && cur_active && cd_zero;
    assign advance    = !(rr_due && pend_valid_reg && !out_free);
    assign table_full = &active_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // countdown after this tick
    always_comb
    begin
        if (mode_reg == pts_pkg::MODE_PRIO)
        begin
            cd_src = is_best ? ram_rd_data.period : ram_rd_data.countdown;
            upd_cd = (cd_src == '0) ? '0 : cd_src - CD_W'(1);
        end
        else
        begin
            cd_src = ram_rd_data.countdown;
            upd_cd = cd_zero ? ram_rd_data.period : cd_src - CD_W'(1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        best_prio_next  = best_prio_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = eval_idx_reg;
        ram_wr_data     = ram_rd_data;
        ram_wr_data.countdown = upd_cd;
        ram_rd_en       = 1'b0;

        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    scan_idx_next   = '0;
                    eval_valid_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (s_tuser == pts_pkg::FUNC_TICK)
                    begin
                        state_next = (mode_reg == pts_pkg::MODE_PRIO) ? pts_pkg::S_SEARCH
                                                                      : pts_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = pts_pkg::S_CREATE;
                    end
                end
            end

            pts_pkg::S_CREATE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (table_full)
                    begin
                        out_kind_next = pts_pkg::KIND_FULL;
                        out_slot_next = '0;
                    end
                    else
                    begin
                        out_kind_next         = pts_pkg::KIND_CREATED;
                        out_slot_next         = SLOT_W'(free_idx);
                        active_next[free_idx] = 1'b1;
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = free_idx;
                        ram_wr_data.countdown = in_delay_reg;
                        ram_wr_data.period    = in_period_reg;
                        ram_wr_data.prio      = in_prio_reg;
                    end
                    state_next = pts_pkg::S_IDLE;
                end
            end

            pts_pkg::S_SEARCH:
            begin
                if (eval_valid_reg && cand)
                begin
                    pend_valid_next = 1'b1;
                    pend_slot_next  = eval_idx_reg;
                    best_prio_next  = ram_rd_data.prio;
                end
                if (pass_done)
                begin
                    state_next    = pts_pkg::S_SCAN;
                    scan_idx_next = '0;
                end
                else if (issue)
                begin
                    ram_rd_en       = 1'b1;
                    eval_valid_next = 1'b1;
                    eval_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next   = scan_idx_reg + CNT_IDX_W'(1);
                end
                else
                begin
                    eval_valid_next = 1'b0;
                end
            end

            pts_pkg::S_SCAN:
            begin
                if (pass_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_last_next   = 1'b1;
                        out_kind_next   = pend_valid_reg ? pts_pkg::KIND_DISPATCH
                                                         : pts_pkg::KIND_IDLE;
                        out_slot_next   = pend_valid_reg ? SLOT_W'(pend_slot_reg) : '0;
                        pend_valid_next = 1'b0;
                        state_next      = pts_pkg::S_IDLE;
                    end
                end
                else if (advance)
                begin
                    if (eval_valid_reg && cur_active)
                    begin
                        ram_wr_en = 1'b1;
                    end
                    if (rr_due)
                    begin
                        // previous due slot is not the last one
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_kind_next  = pts_pkg::KIND_DISPATCH;
                            out_slot_next  = SLOT_W'(pend_slot_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = eval_idx_reg;
                    end
                    if (issue)
                    begin
                        ram_rd_en       = 1'b1;
                        eval_valid_next = 1'b1;
                        eval_idx_next   = scan_idx_reg[IDX_W-1:0];
                        scan_idx_next   = scan_idx_reg + CNT_IDX_W'(1);
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pts_pkg::S_IDLE;
            mode_reg       <= pts_pkg::MODE_RR;
            active_reg     <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg  <= eval_idx_next;
        pend_slot_reg <= pend_slot_next;
        best_prio_reg <= best_prio_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
        if (s_tvalid && s_tready)
        begin
            in_delay_reg  <= s_tdata[CD_W-1:0];
            in_period_reg <= s_tdata[2*CD_W-1:CD_W];
            in_prio_reg   <= s_tdata[2*CD_W+PRIO_W-1:2*CD_W];
        end
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pts_pkg::S_IDLE) |-> (!pend_valid_reg && !eval_valid_reg))
        else $error("scan state left over in idle");

    a_scan_write_active: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && (state_reg == pts_pkg::S_SCAN)) |-> (eval_valid_reg && cur_active))
        else $error("slot memory written for an inactive slot");

    a_search_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pts_pkg::S_SEARCH) |-> !ram_wr_en)
        else $error("slot memory written during search pass");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= CNT_IDX_W'(TABLE))
        else $error("scan index beyond table");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pts_pkg::S_SCAN) && !advance) |=> $stable(eval_idx_reg))
        else $error("scan moved on while stalled");
`endif

endmodule

`default_nettype wire
